### design/swmm_pkg.sv
// Shared types and constants for the sliding window min/max block.
`default_nettype none

package swmm_pkg;

  localparam int SAMPLE_W           = 32;
  localparam int CFG_W              = 7;
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int WINDOW_RESET       = 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // running extremes handed from cell to cell
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
  } tok_t;

endpackage

`default_nettype wire

### design/swmm_cell.sv
// One cell of the chain: holds one history sample and folds it into the passing token.
`default_nettype none

module swmm_cell
  import swmm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       shift_en,
  input  wire logic                       active,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire tok_t                       tok_in,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output tok_t                            tok_out
);

  logic signed [SAMPLE_W-1:0] held;
  logic                       tok_valid;
  logic signed [SAMPLE_W-1:0] tok_lo;
  logic signed [SAMPLE_W-1:0] tok_hi;
  logic signed [SAMPLE_W-1:0] lo_next;
  logic signed [SAMPLE_W-1:0] hi_next;

  always_comb begin
    lo_next = tok_in.lo;
    hi_next = tok_in.hi;
    if (active) begin
      if (held < tok_in.lo) lo_next = held;
      if (held > tok_in.hi) hi_next = held;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) held <= sample_in;
    tok_lo <= lo_next;
    tok_hi <= hi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  assign sample_out    = held;
  assign tok_out.valid = tok_valid;
  assign tok_out.lo    = tok_lo;
  assign tok_out.hi    = tok_hi;

endmodule

`default_nettype wire

### design/sliding_window_min_max.sv
// Top level: sliding window minimum and maximum over a chain of sample cells.
// Flow: a word that completes a window sends a token down the whole cell chain; its
//   result is registered onto the output as the token exits. No new word is taken
//   while the token walks (busy) or the hold slot is full; words that yield no result
//   are taken every cycle while the block is neither busy nor holding a result.
// Reset: synchronous, active high; clears fill count, busy and all valids; window_size = 1.
`default_nettype none

module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write: window_size
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_W-1:0]           cfg_data,
  // sample input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       restart,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      window_min,
  output logic signed [SAMPLE_W-1:0]      window_max
);

  // History cells are not cleared; only entries covered by the fill count are ever used.

  // fill count must hold WINDOW_MAX itself
  localparam int CW = $clog2(WINDOW_MAX + 1);
  // compare width covering both the register and the fill count
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] window_size;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_next;
  logic [EW-1:0]    ws_ext;
  logic [EW-1:0]    w_eff;
  logic             busy;
  logic             start;
  logic             produce;
  logic             accept;

  // second result slot, used only when a result exits while the output is stalled
  logic                       hold_valid;
  logic signed [SAMPLE_W-1:0] hold_min;
  logic signed [SAMPLE_W-1:0] hold_max;

  logic                       shift_en;
  logic [WINDOW_MAX-1:0]      cell_active;
  logic signed [SAMPLE_W-1:0] held [WINDOW_MAX];
  tok_t                       tok  [WINDOW_MAX];
  tok_t                       seed;
  tok_t                       end_tok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !hold_valid;
  assign accept    = in_valid && in_ready;
  assign shift_en  = accept;

  // zero acts as one, anything past storage acts as WINDOW_MAX
  always_comb begin
    ws_ext = EW'(window_size);
    if (ws_ext == '0) begin
      w_eff = EW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      w_eff = EW'(WINDOW_MAX);
    end else begin
      w_eff = ws_ext;
    end
  end

  // restart keeps only the word that carries it; otherwise count up and saturate
  always_comb begin
    if (restart) begin
      fill_next = CW'(1);
    end else if (fill < CW'(WINDOW_MAX)) begin
      fill_next = fill + CW'(1);
    end else begin
      fill_next = fill;
    end
  end

  assign produce = (EW'(fill_next) >= w_eff);

  // token enters cell 0 the cycle after the shift; cell 0 already holds the new word
  assign seed.valid = start;
  assign seed.lo    = SAMPLE_MAX;
  assign seed.hi    = SAMPLE_MIN;

  // cell i belongs to the window when i < effective length; others pass the token through
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic signed [SAMPLE_W-1:0] cell_sample_in;
    tok_t                       cell_tok_in;

    assign cell_active[g] = (EW'(g) < w_eff);

    if (g == 0) begin : g_head
      assign cell_sample_in = sample;
      assign cell_tok_in    = seed;
    end else begin : g_body
      assign cell_sample_in = held[g-1];
      assign cell_tok_in    = tok[g-1];
    end

    swmm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (shift_en),
      .active     (cell_active[g]),
      .sample_in  (cell_sample_in),
      .tok_in     (cell_tok_in),
      .sample_out (held[g]),
      .tok_out    (tok[g])
    );
  end

  assign end_tok = tok[WINDOW_MAX-1];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(WINDOW_RESET);
      fill        <= '0;
      busy        <= 1'b0;
      start       <= 1'b0;
      out_valid   <= 1'b0;
      hold_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) window_size <= cfg_data;

      start <= accept && produce;
      if (accept) begin
        fill <= fill_next;
        if (produce) busy <= 1'b1;
      end
      if (end_tok.valid) busy <= 1'b0;

      // hold is never full when a token exits: accepts stop while it is
      if (end_tok.valid) begin
        if (out_valid && !out_ready) begin
          hold_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        if (hold_valid) begin
          hold_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (end_tok.valid) begin
      if (out_valid && !out_ready) begin
        hold_min <= end_tok.lo;
        hold_max <= end_tok.hi;
      end else begin
        window_min <= end_tok.lo;
        window_max <= end_tok.hi;
      end
    end else if (out_valid && out_ready && hold_valid) begin
      window_min <= hold_min;
      window_max <= hold_max;
    end
  end

endmodule

`default_nettype wire

### design/swmm_checker.sv
// Port-level checks for the sliding window min/max block, bound to the top level.
`default_nettype none

module swmm_checker
  import swmm_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] window_min,
  input wire logic signed [SAMPLE_W-1:0] window_max
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_min) && $stable(window_max))
    else $error("result word changed while stalled");

  // extremes of one window are ordered
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_min <= window_max)
    else $error("window_min above window_max");

  // a word is only taken with the chain empty, so no result can appear the cycle after
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after an accept");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .window_min (window_min),
  .window_max (window_max)
);

`default_nettype wire

### tb/tb_sliding_window_min_max.sv
// Self-checking testbench for the sliding window min/max block.
`default_nettype none

module tb_sliding_window_min_max;
  import swmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = WINDOW_MAX_DEFAULT;
  // cell chain depth plus a little slack
  localparam int SETTLE     = DEPTH + 8;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 84;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_PHASE = 2;
  // window_size per random phase: extremes, out-of-range values and a few in between
  localparam int PHASE_WINDOWS [PHASES] = '{64, 127, 2, 65, 3, 17, 1, 0, 63, 5, 100, 8};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
  } extremes_t;

  // Tracks the sample history and window setting, predicts the extremes of
  // each full window and checks the results in order.
  class window_tracker;
    logic signed [SAMPLE_W-1:0] history [DEPTH];
    logic [CFG_W-1:0]           window_len;
    int unsigned                fill;
    extremes_t                  pending_extremes [$];
    int unsigned                errors;

    function new();
      foreach (history[i]) history[i] = '0;
      window_len = CFG_W'(WINDOW_RESET);
      fill       = 0;
      errors     = 0;
    endfunction

    function void set_window(input logic [CFG_W-1:0] len);
      window_len = len;
    endfunction

    function int unsigned active_len();
      if (window_len == 0) return 1;
      if (window_len > DEPTH) return DEPTH;
      return 32'(window_len);
    endfunction

    // note an accepted sample word; queue its extremes once the window is full
    function void take_sample(input logic signed [SAMPLE_W-1:0] s, input logic r);
      int unsigned w;
      extremes_t   e;
      for (int i = DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      if (r) fill = 1;
      else if (fill < DEPTH) fill++;
      w = active_len();
      if (fill < w) return;
      e.lo = s;
      e.hi = s;
      for (int i = 1; i < w; i++) begin
        if (history[i] < e.lo) e.lo = history[i];
        if (history[i] > e.hi) e.hi = history[i];
      end
      pending_extremes.push_back(e);
    endfunction

    function void check_extremes(input logic signed [SAMPLE_W-1:0] lo,
                                 input logic signed [SAMPLE_W-1:0] hi);
      extremes_t e;
      if (pending_extremes.size() == 0) begin
        $display("%0t ns: result with none pending: min %0d max %0d", $time, lo, hi);
        errors++;
        return;
      end
      e = pending_extremes.pop_front();
      if (lo !== e.lo) begin
        $display("%0t ns: window_min expected %0d got %0d", $time, e.lo, lo);
        errors++;
      end
      if (hi !== e.hi) begin
        $display("%0t ns: window_max expected %0d got %0d", $time, e.hi, hi);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_extremes.size();
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic                       restart   = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] window_min;
  logic signed [SAMPLE_W-1:0] window_max;

  // idling switches for the sender and the receiver, and the long-hold request
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_req       = 1'b0;

  window_tracker tracker = new();

  sliding_window_min_max dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_min (window_min),
    .window_max (window_max)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (every word yielding a result
  // through the full chain, with worst-case gaps on both sides).
  initial begin
    #2_000_000;
    $display("tb_sliding_window_min_max: FAIL");
    $finish;
  end

  // Result side: random stall bursts, one long hold on request, otherwise ready.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sample the result port before the edge updates anything.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_extremes(window_min, window_max);
  end

  // Offer one sample word and hold it until taken. Valid stays high on return,
  // so back-to-back words drop it in between only when the sender idles.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic r);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= r;
    do @(posedge clk); while (!in_ready);
    tracker.take_sample(s, r);
  endtask

  // Stop sending, let every pending result out, then give the chain time to
  // flush words that produce no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // window_size write; only called with the block idle
  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_window(len);
  endtask

  // Mix of rails, small values that tie often, and full-range noise.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return int'($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned eff;
    logic [CFG_W-1:0] len;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset window of 1, rails and sign boundary
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b1);
    drain();

    // Window widened mid-sequence, then restarts inside a partly filled window
    write_window(CFG_W'(3));
    push_sample(5, 1'b0);
    push_sample(SAMPLE_MIN, 1'b1);
    push_sample(7, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(-3, 1'b0);
    push_sample('0, 1'b1);
    push_sample(2, 1'b0);
    push_sample(2, 1'b0);
    push_sample(2, 1'b0);
    drain();

    // zero length behaves as one
    write_window('0);
    push_sample(-5, 1'b0);
    push_sample(9, 1'b1);
    drain();

    // all-ones length clamps to the storage depth; nothing fills yet
    write_window('1);
    push_sample(4, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    drain();

    // Random phases: one window setting each, mostly long runs between
    // restarts so windows actually fill.
    for (int p = 0; p < PHASES; p++) begin
      len = CFG_W'(PHASE_WINDOWS[p]);
      write_window(len);
      eff = tracker.active_len();
      // quiet stretch mid-run and for the tail of the test
      sender_idles   = !(p == 6 || p >= PHASES - 2);
      receiver_idles = sender_idles;
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        // about half the phases, at random, keep the old history across the length change
        if (n == 0) push_sample(rand_sample(), 1'($urandom_range(0, 1)));
        else push_sample(rand_sample(), $urandom_range(0, 3 * eff + 20) == 0);
      end
      drain();
    end

    if (tracker.errors == 0) begin
      $display("tb_sliding_window_min_max: PASS");
    end else begin
      $display("tb_sliding_window_min_max: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/swmm_pkg.sv
design/swmm_cell.sv
design/sliding_window_min_max.sv
design/swmm_checker.sv
tb/tb_sliding_window_min_max.sv
